// ===== sv/rtcl_pkg.sv =====
// Shared types, constants and calendar helpers for the local time unit.
`timescale 1ns / 1ps
`default_nettype none

package rtcl_pkg;

	localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W = 11;

	localparam logic [CFG_INDEX_W-1:0] CFG_CLOCK_HOLDS_UTC = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ZONE_OFFSET_MINUTES = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_SUMMER_TIME_ENABLE = 2'd2;

	localparam logic signed [10:0] ZONE_OFFSET_RESET = 11'sd60;

	localparam int unsigned MINUTES_PER_DAY = 1440;
	localparam int unsigned DIV100_MUL = 83887;
	localparam int unsigned DIV100_SHIFT = 23;
	localparam int unsigned DIV60_MUL = 2185;
	localparam int unsigned DIV60_SHIFT = 17;

	localparam logic [4:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef struct packed {
		logic [15:0] in_year;
		logic [3:0]  in_month;
		logic [4:0]  in_day;
		logic [2:0]  in_weekday;
		logic [4:0]  in_hour;
		logic [5:0]  in_minute;
		logic [5:0]  in_second;
	} rtcl_in_t;

	typedef struct packed {
		logic [15:0] out_year;
		logic [3:0]  out_month;
		logic [4:0]  out_day;
		logic [2:0]  out_weekday;
		logic [4:0]  out_hour;
		logic [5:0]  out_minute;
		logic [5:0]  out_second;
		logic        summer_time_applied;
	} rtcl_out_t;

	typedef struct packed {
		logic              clock_holds_utc;
		logic signed [10:0] zone_offset_minutes;
		logic              summer_time_enable;
	} rtcl_cfg_t;

	typedef struct packed {
		logic [15:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [2:0]  weekday;
	} rtcl_date_t;

	typedef struct packed {
		rtcl_date_t  date;
		logic        keep_time;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [10:0] minute_of_day;
		logic        back_first;
		logic [1:0]  fwd_count;
		logic        leap;
		logic [5:0]  second;
		logic        extra;
	} rtcl_job_t;

	function automatic logic [4:0] month_days(input logic leap, input logic [3:0] month);
		logic [4:0] len;
		if (month < 4'd1 || month > 4'd12) begin
			len = 5'd31;
		end else if (month == 4'd2 && leap) begin
			len = 5'd29;
		end else begin
			len = MONTH_LEN[month - 4'd1];
		end
		return len;
	endfunction

	// Residue modulo 7 by summing octal digits, since 8 is 1 modulo 7.
	function automatic logic [2:0] mod7(input logic [17:0] x);
		logic [5:0] sum1;
		logic [3:0] sum2;
		logic [3:0] res;
		sum1 = {3'b000, x[2:0]} + {3'b000, x[5:3]} + {3'b000, x[8:6]}
			+ {3'b000, x[11:9]} + {3'b000, x[14:12]} + {3'b000, x[17:15]};
		sum2 = {1'b0, sum1[5:3]} + {1'b0, sum1[2:0]};
		res = (sum2 >= 4'd7) ? sum2 - 4'd7 : sum2;
		return res[2:0];
	endfunction

	// One calendar day forward or back, with the odd-input rules of the unit.
	function automatic rtcl_date_t step_day(input logic fwd, input logic leap,
		input rtcl_date_t d);
		rtcl_date_t r;
		logic [4:0] len;
		r = d;
		len = month_days(leap, d.month);
		if (fwd) begin
			if (d.day < len) begin
				r.day = d.day + 5'd1;
			end else begin
				r.day = 5'd1;
				if (d.month < 4'd12) begin
					r.month = d.month + 4'd1;
				end else begin
					r.month = 4'd1;
					r.year = d.year + 16'd1;
				end
			end
			if (d.weekday == 3'd6) begin
				r.weekday = 3'd0;
			end else if (d.weekday == 3'd7) begin
				r.weekday = 3'd1;
			end else begin
				r.weekday = d.weekday + 3'd1;
			end
		end else begin
			if (d.day > 5'd1) begin
				r.day = d.day - 5'd1;
			end else begin
				if (d.month > 4'd1) begin
					r.month = d.month - 4'd1;
				end else begin
					r.month = 4'd12;
					r.year = d.year - 16'd1;
				end
				r.day = month_days(leap, r.month);
			end
			if (d.weekday == 3'd0 || d.weekday == 3'd7) begin
				r.weekday = 3'd6;
			end else begin
				r.weekday = d.weekday - 3'd1;
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/rtcl_front.sv =====
// Front end: accepts words, finds summer time and the minute and day shifts.
`timescale 1ns / 1ps
`default_nettype none

module rtcl_front import rtcl_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire rtcl_cfg_t cfg,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire rtcl_in_t  in_word,
	input  wire logic [CW-1:0] queue_count,
	output logic           push,
	output rtcl_job_t      push_job
);

	logic        valid_s1;
	rtcl_in_t    word_s1;
	logic [32:0] prod_s1;

	logic        valid_s2;
	rtcl_in_t    word_s2;
	logic        leap_s2;
	logic [4:0]  sun_mar_s2;
	logic [4:0]  sun_oct_s2;
	logic [10:0] t0_s2;
	logic [10:0] n1_s2;
	logic        back1_s2;
	logic [1:0]  fwd1_s2;

	logic [CW:0] occupancy;
	logic        accept;

	logic [9:0]  q100;
	logic [15:0] r100;
	logic        leap;
	logic [17:0] dsum;
	logic [2:0]  dow_mar;
	logic [2:0]  dow_oct;
	logic [10:0] t0;
	logic signed [12:0] total1;
	logic [12:0] n1_full;
	logic        back1;
	logic [1:0]  fwd1;

	logic        rule;
	logic [4:0]  start_hour;
	logic [4:0]  end_hour;
	logic        extra;
	logic        shifted1;
	logic [10:0] total2;
	logic        d2;
	logic [10:0] n2;

	assign occupancy = (CW + 1)'(valid_s1) + (CW + 1)'(valid_s2) + {1'b0, queue_count};
	assign in_ready = occupancy < (CW + 1)'(QUEUE_DEPTH);
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= in_word;
			prod_s1 <= {17'b0, in_word.in_year} * 33'(DIV100_MUL);
		end
	end

	always_comb begin
		q100 = prod_s1[DIV100_SHIFT +: 10];
		r100 = word_s1.in_year - ({6'b0, q100} * 16'd100);
		leap = (word_s1.in_year[1:0] == 2'b00) && ((r100 != 16'd0) || (q100[1:0] == 2'b00));
		dsum = {2'b00, word_s1.in_year} + {4'b0000, word_s1.in_year[15:2]}
			- {8'b0, q100} + {10'b0, q100[9:2]};
		dow_mar = mod7(dsum + 18'd33);
		dow_oct = mod7(dsum + 18'd37);

		t0 = {word_s1.in_hour, 6'b0} - {4'b0, word_s1.in_hour, 2'b0}
			+ {5'b0, word_s1.in_minute};
		total1 = $signed({2'b00, t0}) + $signed({{2{cfg.zone_offset_minutes[10]}},
			cfg.zone_offset_minutes});
		back1 = 1'b0;
		fwd1 = 2'd0;
		if (total1 < 13'sd0) begin
			back1 = 1'b1;
			n1_full = 13'(total1 + 13'sd1440);
		end else if (total1 >= 13'sd2880) begin
			fwd1 = 2'd2;
			n1_full = 13'(total1 - 13'sd2880);
		end else if (total1 >= 13'sd1440) begin
			fwd1 = 2'd1;
			n1_full = 13'(total1 - 13'sd1440);
		end else begin
			n1_full = 13'(total1);
		end
	end

	always_ff @(posedge clk) begin
		word_s2 <= word_s1;
		leap_s2 <= leap;
		sun_mar_s2 <= 5'd31 - {2'b00, dow_mar};
		sun_oct_s2 <= 5'd31 - {2'b00, dow_oct};
		t0_s2 <= t0;
		n1_s2 <= n1_full[10:0];
		back1_s2 <= back1;
		fwd1_s2 <= fwd1;
	end

	always_comb begin
		start_hour = cfg.clock_holds_utc ? 5'd1 : 5'd2;
		end_hour = cfg.clock_holds_utc ? 5'd1 : 5'd3;
		if (word_s2.in_month < 4'd3 || word_s2.in_month > 4'd10) begin
			rule = 1'b0;
		end else if (word_s2.in_month > 4'd3 && word_s2.in_month < 4'd10) begin
			rule = 1'b1;
		end else if (word_s2.in_month == 4'd3) begin
			if (word_s2.in_day > sun_mar_s2) begin
				rule = 1'b1;
			end else if (word_s2.in_day < sun_mar_s2) begin
				rule = 1'b0;
			end else begin
				rule = word_s2.in_hour >= start_hour;
			end
		end else begin
			if (word_s2.in_day < sun_oct_s2) begin
				rule = 1'b1;
			end else if (word_s2.in_day > sun_oct_s2) begin
				rule = 1'b0;
			end else begin
				rule = word_s2.in_hour < end_hour;
			end
		end
		extra = cfg.summer_time_enable && rule;
		shifted1 = cfg.clock_holds_utc && (cfg.zone_offset_minutes != 11'sd0);
		total2 = (shifted1 ? n1_s2 : t0_s2) + 11'd60;
		d2 = total2 >= 11'(MINUTES_PER_DAY);
		n2 = d2 ? total2 - 11'(MINUTES_PER_DAY) : total2;

		push = valid_s2;
		push_job.date.year = word_s2.in_year;
		push_job.date.month = word_s2.in_month;
		push_job.date.day = word_s2.in_day;
		push_job.date.weekday = word_s2.in_weekday;
		push_job.keep_time = !shifted1 && !extra;
		push_job.hour = word_s2.in_hour;
		push_job.minute = word_s2.in_minute;
		push_job.minute_of_day = extra ? n2 : n1_s2;
		push_job.back_first = shifted1 && back1_s2;
		push_job.fwd_count = ((shifted1 && !back1_s2) ? fwd1_s2 : 2'd0)
			+ {1'b0, extra && d2};
		push_job.leap = leap_s2;
		push_job.second = word_s2.in_second;
		push_job.extra = extra;
	end

endmodule

`default_nettype wire

// ===== sv/rtcl_fifo.sv =====
// Short queue of classified words between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module rtcl_fifo import rtcl_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1),
	localparam int unsigned PW = $clog2(QUEUE_DEPTH)
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire rtcl_job_t push_job,
	input  wire logic      pop,
	output rtcl_job_t      head_job,
	output logic           not_empty,
	output logic [CW-1:0]  count
);

	rtcl_job_t     mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign head_job = mem_q[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

// ===== sv/rtcl_back.sv =====
// Back end: rolls the date, splits hour and minute, and holds the result word.
`timescale 1ns / 1ps
`default_nettype none

module rtcl_back import rtcl_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire rtcl_job_t head_job,
	input  wire logic      not_empty,
	output logic           pop,
	output logic           out_valid,
	input  wire logic      out_ready,
	output rtcl_out_t      out_word
);

	logic       out_valid_q;
	rtcl_out_t  out_word_q;

	logic       en0;
	logic       en1;
	logic       en2;
	rtcl_date_t date0;
	rtcl_date_t date1;
	rtcl_date_t date2;
	rtcl_date_t date3;
	logic [22:0] prod60;
	logic [4:0]  hour_calc;
	logic [10:0] hour_min;
	logic [10:0] minute_calc;
	rtcl_out_t   result;

	assign pop = not_empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_word = out_word_q;

	always_comb begin
		en0 = head_job.back_first || (head_job.fwd_count != 2'd0);
		en1 = head_job.back_first ? (head_job.fwd_count != 2'd0)
			: (head_job.fwd_count >= 2'd2);
		en2 = !head_job.back_first && (head_job.fwd_count == 2'd3);

		date0 = head_job.date;
		date1 = en0 ? step_day(!head_job.back_first, head_job.leap, date0) : date0;
		date2 = en1 ? step_day(1'b1, head_job.leap, date1) : date1;
		date3 = en2 ? step_day(1'b1, head_job.leap, date2) : date2;

		prod60 = {12'b0, head_job.minute_of_day} * 23'(DIV60_MUL);
		hour_calc = prod60[DIV60_SHIFT +: 5];
		hour_min = {hour_calc, 6'b0} - {4'b0, hour_calc, 2'b0};
		minute_calc = head_job.minute_of_day - hour_min;

		result.out_year = date3.year;
		result.out_month = date3.month;
		result.out_day = date3.day;
		result.out_weekday = date3.weekday;
		result.out_hour = head_job.keep_time ? head_job.hour : hour_calc;
		result.out_minute = head_job.keep_time ? head_job.minute : minute_calc[5:0];
		result.out_second = head_job.second;
		result.summer_time_applied = head_job.extra;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_word_q <= result;
		end
	end

endmodule

`default_nettype wire

// ===== sv/rtc_local_time_with_eu_dst_unit.sv =====
// Top level of the local time unit with EU summer time.
`timescale 1ns / 1ps
`default_nettype none

// The unit turns one clock reading into local date and time and takes one word per
// cycle while in_ready is high. An accepted word passes the two front stages, is
// written into the queue and is then loaded into the output register once that
// register is empty or being taken. The two front stages and the queue together hold
// up to QUEUE_DEPTH words; in_ready falls when that many are held, so a stalled output
// stops the input after QUEUE_DEPTH + 1 words, counting the one in the output register.
// Registers must be written only while the unit is idle; the unit does not enforce it.

module rtc_local_time_with_eu_dst_unit import rtcl_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire rtcl_in_t               in_word,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output rtcl_out_t                   out_word
);

	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	logic              clock_holds_utc_q;
	logic signed [10:0] zone_offset_minutes_q;
	logic              summer_time_enable_q;
	rtcl_cfg_t         cfg;

	logic          push;
	rtcl_job_t     push_job;
	logic          pop;
	rtcl_job_t     head_job;
	logic          not_empty;
	logic [CW-1:0] queue_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_holds_utc_q <= 1'b1;
			zone_offset_minutes_q <= ZONE_OFFSET_RESET;
			summer_time_enable_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CLOCK_HOLDS_UTC: begin
					clock_holds_utc_q <= cfg_wdata[0];
				end
				CFG_ZONE_OFFSET_MINUTES: begin
					zone_offset_minutes_q <= $signed(cfg_wdata[10:0]);
				end
				CFG_SUMMER_TIME_ENABLE: begin
					summer_time_enable_q <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.clock_holds_utc = clock_holds_utc_q;
	assign cfg.zone_offset_minutes = zone_offset_minutes_q;
	assign cfg.summer_time_enable = summer_time_enable_q;

	rtcl_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_word    (in_word),
		.queue_count(queue_count),
		.push       (push),
		.push_job   (push_job)
	);

	rtcl_fifo #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.not_empty(not_empty),
		.count    (queue_count)
	);

	rtcl_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_job (head_job),
		.not_empty(not_empty),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word)
	);

endmodule

`default_nettype wire

// ===== dv/tb_rtc_local_time_with_eu_dst_unit.sv =====
// Testbench for the local time unit, checked against a calendar predictor.
`timescale 1ns / 1ps

module tb_rtc_local_time_with_eu_dst_unit;
	import rtcl_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned RANDOM_WORDS = 1450;

	typedef struct packed {
		logic [15:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [2:0]  weekday;
		logic [4:0]  hour;
		logic [5:0]  minute;
	} clock_stamp_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	rtcl_in_t               in_word = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	rtcl_out_t              out_word;

	bit                  utc_mode = 1'b1;
	logic signed [10:0]  zone_offset = 11'sd60;
	bit                  dst_enable = 1'b1;
	bit                  steady = 1'b0;
	rtcl_out_t           local_time_q[$];
	int unsigned         mismatches = 0;
	int unsigned         cycle_count = 0;

	rtc_local_time_with_eu_dst_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= 31);
	end

	function automatic bit is_leap(int y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int days_in(int y, int m);
		int lengths [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		if (m < 1 || m > 12) return 31;
		if (m == 2 && is_leap(y)) return 29;
		return lengths[m - 1];
	endfunction

	function automatic int weekday_of(int y, int m, int d);
		int keys [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
		if (m < 3) y = (y - 1) & 'hFFFF;
		return (y + y / 4 - y / 100 + y / 400 + keys[(m - 1) % 12] + d) % 7;
	endfunction

	function automatic int last_sunday(int y, int m);
		int n;
		n = days_in(y, m);
		return n - weekday_of(y, m, n);
	endfunction

	function automatic bit summer_holds(clock_stamp_t s, int start_hour, int end_hour);
		int march_day;
		int october_day;
		march_day = last_sunday(int'(s.year), 3);
		october_day = last_sunday(int'(s.year), 10);
		if (s.month < 3 || s.month > 10) return 1'b0;
		if (s.month > 3 && s.month < 10) return 1'b1;
		if (s.month == 3) begin
			if (s.day > march_day) return 1'b1;
			if (s.day < march_day) return 1'b0;
			return s.hour >= start_hour;
		end
		if (s.day < october_day) return 1'b1;
		if (s.day > october_day) return 1'b0;
		return s.hour < end_hour;
	endfunction

	function automatic clock_stamp_t shifted(clock_stamp_t s, int delta);
		int total;
		int days;
		days = 0;
		if (delta == 0) return s;
		total = int'(s.hour) * 60 + int'(s.minute) + delta;
		while (total < 0) begin
			total += 1440;
			days--;
		end
		while (total >= 1440) begin
			total -= 1440;
			days++;
		end
		s.hour = 5'(total / 60);
		s.minute = 6'(total % 60);
		while (days > 0) begin
			if (int'(s.day) < days_in(int'(s.year), int'(s.month))) begin
				s.day = s.day + 5'd1;
			end else begin
				s.day = 5'd1;
				if (s.month < 4'd12) begin
					s.month = s.month + 4'd1;
				end else begin
					s.month = 4'd1;
					s.year = s.year + 16'd1;
				end
			end
			s.weekday = 3'((int'(s.weekday) + 1) % 7);
			days--;
		end
		while (days < 0) begin
			if (s.day > 5'd1) begin
				s.day = s.day - 5'd1;
			end else begin
				if (s.month > 4'd1) begin
					s.month = s.month - 4'd1;
				end else begin
					s.month = 4'd12;
					s.year = s.year - 16'd1;
				end
				s.day = 5'(days_in(int'(s.year), int'(s.month)));
			end
			s.weekday = 3'((int'(s.weekday) + 6) % 7);
			days++;
		end
		return s;
	endfunction

	function automatic rtcl_out_t predict_local_time(rtcl_in_t w);
		clock_stamp_t src;
		clock_stamp_t loc;
		rtcl_out_t    r;
		bit           extra;
		extra = 1'b0;
		src.year = w.in_year;
		src.month = w.in_month;
		src.day = w.in_day;
		src.weekday = w.in_weekday;
		src.hour = w.in_hour;
		src.minute = w.in_minute;
		loc = src;
		if (utc_mode) begin
			loc = shifted(loc, int'(zone_offset));
			if (dst_enable && summer_holds(src, 1, 1)) begin
				loc = shifted(loc, 60);
				extra = 1'b1;
			end
		end else if (dst_enable && summer_holds(src, 2, 3)) begin
			loc = shifted(loc, 60);
			extra = 1'b1;
		end
		r.out_year = loc.year;
		r.out_month = loc.month;
		r.out_day = loc.day;
		r.out_weekday = loc.weekday;
		r.out_hour = loc.hour;
		r.out_minute = loc.minute;
		r.out_second = w.in_second;
		r.summer_time_applied = extra;
		return r;
	endfunction

	function automatic rtcl_in_t raw_reading(int y, int m, int d, int wd, int h, int mi, int s);
		rtcl_in_t w;
		w.in_year = 16'(y);
		w.in_month = 4'(m);
		w.in_day = 5'(d);
		w.in_weekday = 3'(wd);
		w.in_hour = 5'(h);
		w.in_minute = 6'(mi);
		w.in_second = 6'(s);
		return w;
	endfunction

	function automatic rtcl_in_t reading(int y, int m, int d, int h, int mi, int s);
		return raw_reading(y, m, d, weekday_of(y, m, d), h, mi, s);
	endfunction

	function automatic rtcl_in_t random_reading();
		int kind;
		int y;
		int m;
		int d;
		int h;
		int mi;
		kind = $urandom_range(99);
		if (kind < 15) begin
			return raw_reading($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom());
		end
		y = ($urandom_range(3) == 0) ? $urandom_range(65535) : 1970 + $urandom_range(250);
		mi = $urandom_range(59);
		if (kind < 55) begin
			m = $urandom_range(1) ? 10 : 3;
			d = last_sunday(y, m) + $urandom_range(2) - 1;
			if (d > days_in(y, m)) d = days_in(y, m);
			h = $urandom_range(4);
			if ($urandom_range(3) == 0) mi = $urandom_range(1) ? 59 : 0;
		end else if (kind < 75) begin
			m = $urandom_range(1, 12);
			d = $urandom_range(1) ? days_in(y, m) : 1;
			h = $urandom_range(1) ? $urandom_range(1) : 22 + $urandom_range(1);
		end else begin
			m = $urandom_range(1, 12);
			d = $urandom_range(1, days_in(y, m));
			h = $urandom_range(23);
		end
		return reading(y, m, d, h, mi, $urandom_range(59));
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	task automatic check_word(input rtcl_out_t got, input rtcl_out_t want);
		check_field("out_year", int'(got.out_year), int'(want.out_year));
		check_field("out_month", int'(got.out_month), int'(want.out_month));
		check_field("out_day", int'(got.out_day), int'(want.out_day));
		check_field("out_weekday", int'(got.out_weekday), int'(want.out_weekday));
		check_field("out_hour", int'(got.out_hour), int'(want.out_hour));
		check_field("out_minute", int'(got.out_minute), int'(want.out_minute));
		check_field("out_second", int'(got.out_second), int'(want.out_second));
		check_field("summer_time_applied", int'(got.summer_time_applied),
			int'(want.summer_time_applied));
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (local_time_q.size() == 0) begin
				report_mismatch($sformatf("word with no expectation: %h", out_word));
			end else begin
				check_word(out_word, local_time_q.pop_front());
			end
		end
	end

	task automatic send_reading(input rtcl_in_t w);
		@(negedge clk);
		if (!steady) begin
			while ($urandom_range(99) < 31) begin
				in_valid = 1'b0;
				@(negedge clk);
			end
		end
		in_valid = 1'b1;
		in_word = w;
		do @(posedge clk); while (!in_ready);
		local_time_q.push_back(predict_local_time(w));
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (local_time_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
		input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_wdata = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic apply_settings(input bit utc, input logic signed [10:0] offset, input bit dst);
		drain();
		write_register(CFG_CLOCK_HOLDS_UTC, {10'd0, utc});
		write_register(CFG_ZONE_OFFSET_MINUTES, offset);
		write_register(CFG_SUMMER_TIME_ENABLE, {10'd0, dst});
		utc_mode = utc;
		zone_offset = offset;
		dst_enable = dst;
	endtask

	task automatic test_reset_settings();
		send_reading(reading(2024, 1, 15, 12, 0, 0));
		send_reading(reading(2024, 7, 1, 23, 30, 45));
		send_reading(reading(2024, 3, last_sunday(2024, 3), 0, 59, 59));
		send_reading(reading(2024, 3, last_sunday(2024, 3), 1, 0, 0));
		send_reading(reading(2024, 10, last_sunday(2024, 10), 0, 59, 59));
		send_reading(reading(2024, 10, last_sunday(2024, 10), 1, 0, 0));
		send_reading(reading(2023, 12, 31, 23, 59, 59));
		send_reading(reading(2024, 2, 28, 23, 30, 1));
	endtask

	task automatic test_offset_extremes();
		apply_settings(1'b1, -11'sd720, 1'b0);
		send_reading(reading(2024, 3, 1, 5, 0, 0));
		send_reading(reading(0, 1, 1, 0, 0, 0));
		apply_settings(1'b1, 11'sd840, 1'b1);
		send_reading(reading(65535, 12, 31, 23, 0, 30));
		apply_settings(1'b1, 11'sd0, 1'b0);
		send_reading(raw_reading(65535, 15, 31, 7, 31, 63, 63));
		send_reading(raw_reading(0, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_local_rule();
		apply_settings(1'b0, 11'sd60, 1'b1);
		send_reading(reading(2025, 3, last_sunday(2025, 3), 1, 59, 10));
		send_reading(reading(2025, 3, last_sunday(2025, 3), 2, 0, 10));
		send_reading(reading(2025, 10, last_sunday(2025, 10), 2, 59, 10));
		send_reading(reading(2025, 10, last_sunday(2025, 10), 3, 0, 10));
		apply_settings(1'b0, 11'sd60, 1'b0);
		send_reading(reading(2025, 7, 1, 12, 0, 0));
	endtask

	task automatic test_odd_fields();
		apply_settings(1'b1, 11'sd840, 1'b1);
		send_reading(raw_reading(2024, 0, 0, 7, 31, 63, 63));
		send_reading(raw_reading(2024, 13, 31, 3, 23, 0, 1));
		apply_settings(1'b1, -11'sd720, 1'b1);
		send_reading(raw_reading(2024, 0, 1, 2, 0, 0, 5));
		send_reading(raw_reading(2024, 14, 0, 7, 3, 0, 0));
		send_reading(raw_reading(2024, 3, 1, 7, 2, 15, 9));
	endtask

	task automatic test_random_readings();
		int unsigned sent;
		int unsigned phase;
		int unsigned count;
		int          pick;
		logic signed [10:0] offset;
		sent = 0;
		phase = 0;
		while (sent < RANDOM_WORDS) begin
			case (phase)
				0: apply_settings(1'b1, 11'sd60, 1'b1);
				1: apply_settings(1'b1, -11'sd720, 1'b1);
				2: apply_settings(1'b1, 11'sd840, 1'b1);
				3: apply_settings(1'b0, 11'sd0, 1'b1);
				4: apply_settings(1'b1, 11'sd0, 1'b0);
				default: begin
					pick = $urandom_range(7);
					if (pick == 0) offset = -11'sd720;
					else if (pick == 1) offset = 11'sd840;
					else if (pick == 2) offset = 11'sd0;
					else offset = 11'($signed($urandom_range(1560)) - 720);
					apply_settings(1'($urandom_range(1)), offset, $urandom_range(3) != 0);
				end
			endcase
			steady = (phase == 0);
			count = (phase == 0) ? 200 : $urandom_range(80, 160);
			repeat (count) begin
				if (sent < RANDOM_WORDS) begin
					send_reading(random_reading());
					sent++;
				end
			end
			phase++;
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_settings();
		test_offset_extremes();
		test_local_rule();
		test_odd_fields();
		test_random_readings();
		drain();
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
